### src/icu_pkg.sv
// ----------------------------------------------------------------------------
// icu_pkg
// Shared widths, limits and the control record that moves along the chain.
// ----------------------------------------------------------------------------
package icu_pkg;

    localparam int VALUE_W   = 32;
    localparam int GREATER_W = 6;
    localparam int TOTAL_W   = 11;

    localparam logic [GREATER_W-1:0] GREATER_MAX = '1;
    localparam logic [TOTAL_W-1:0]   TOTAL_MAX   = '1;

    typedef struct packed {
        logic valid;
        logic start_new;
        logic too_many;
    } t_tok_ctl;

endpackage

### src/icu_cell.sv
// ----------------------------------------------------------------------------
// icu_cell
// One element slot: stores the element whose index matches this slot and
// counts it against every later item that passes.
// ----------------------------------------------------------------------------
module icu_cell import icu_pkg::*; #(
    parameter int CNT_W    = 7,
    parameter int CELL_IDX = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  t_tok_ctl                  i_ctl,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic [CNT_W-1:0]          i_idx,
    input  logic [CNT_W-1:0]          i_cnt,
    output t_tok_ctl                  o_ctl,
    output logic signed [VALUE_W-1:0] o_value,
    output logic [CNT_W-1:0]          o_idx,
    output logic [CNT_W-1:0]          o_cnt
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

    t_tok_ctl                  r_ctl;
    logic signed [VALUE_W-1:0] r_stored;
    logic signed [VALUE_W-1:0] r_value;
    logic [CNT_W-1:0]          r_idx;
    logic [CNT_W-1:0]          r_cnt;
    logic [CNT_W-1:0]          n_cnt;
    logic                      hit;
    logic                      wr;

    assign hit   = i_ctl.valid && (MY_IDX < i_idx) && (r_stored > i_value);
    assign wr    = i_en && i_ctl.valid && !i_ctl.too_many && (i_idx == MY_IDX);
    assign n_cnt = i_cnt + CNT_W'(hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= i_value;
            r_idx   <= i_idx;
            r_cnt   <= n_cnt;
        end
        if (wr) begin
            r_stored <= i_value;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_value = r_value;
    assign o_idx   = r_idx;
    assign o_cnt   = r_cnt;

endmodule

### src/icu_total.sv
// ----------------------------------------------------------------------------
// icu_total
// End of the chain: keeps the running total and holds the result item.
// ----------------------------------------------------------------------------
module icu_total import icu_pkg::*; #(
    parameter int CNT_W = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_tok_ctl             i_ctl,
    input  logic [CNT_W-1:0]     i_cnt,
    output logic                 o_valid,
    output logic [GREATER_W-1:0] o_greater_before,
    output logic [TOTAL_W-1:0]   o_inversions,
    output logic                 o_too_many
);

    localparam int SUM_W = ((CNT_W > TOTAL_W) ? CNT_W : TOTAL_W) + 1;

    logic                 r_valid;
    logic [TOTAL_W-1:0]   r_total;
    logic [GREATER_W-1:0] r_greater;
    logic [TOTAL_W-1:0]   r_inv;
    logic                 r_too_many;
    logic [TOTAL_W-1:0]   n_total;
    logic [GREATER_W-1:0] n_greater;
    logic [SUM_W-1:0]     cnt_ext;
    logic [SUM_W-1:0]     base_ext;
    logic [SUM_W-1:0]     sum;
    logic [SUM_W-1:0]     greater_ext;

    assign cnt_ext  = SUM_W'(i_cnt);
    assign base_ext = i_ctl.start_new ? '0 : SUM_W'(r_total);
    assign sum      = base_ext + cnt_ext;

    assign greater_ext = (cnt_ext > SUM_W'(GREATER_MAX)) ? SUM_W'(GREATER_MAX) : cnt_ext;

    always_comb begin
        if (i_ctl.too_many) begin
            n_total   = r_total;
            n_greater = '0;
        end else begin
            n_total   = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
            n_greater = greater_ext[GREATER_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_total <= '0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
            if (i_ctl.valid) begin
                r_total <= n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_ctl.valid) begin
            r_greater  <= n_greater;
            r_inv      <= n_total;
            r_too_many <= i_ctl.too_many;
        end
    end

    assign o_valid          = r_valid;
    assign o_greater_before = r_greater;
    assign o_inversions     = r_inv;
    assign o_too_many       = r_too_many;

endmodule

### src/inversion_counter_unit.sv
// ----------------------------------------------------------------------------
// inversion_counter_unit
// Inversion counter: each item passes a row of element cells, picking up the
// count of stored earlier elements greater than it, and is stored in its slot.
// ----------------------------------------------------------------------------
//  channel | valid   | ready   | payload
//  in      | i_valid | o_ready | i_value, i_start_new
//  out     | o_valid | i_ready | o_greater_before, o_inversions, o_too_many
//
//  one item per cycle while the output is not stalled; each item passes
//  through every cell register of the row and then the total register
//  a stalled output freezes the whole row; o_ready is high while the output
//  register is empty or being taken
//  reset clears the element count, the total and all item valid flags
module inversion_counter_unit import icu_pkg::*; #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_start_new,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [GREATER_W-1:0]      o_greater_before,
    output logic [TOTAL_W-1:0]        o_inversions,
    output logic                      o_too_many
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_ITEMS);

    logic                      en;
    logic                      full;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic [CNT_W-1:0]          entry_idx;

    t_tok_ctl                  c_ctl   [0:MAX_ITEMS];
    logic signed [VALUE_W-1:0] c_value [0:MAX_ITEMS];
    logic [CNT_W-1:0]          c_idx   [0:MAX_ITEMS];
    logic [CNT_W-1:0]          c_cnt   [0:MAX_ITEMS];

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // slot assignment at entry
    assign full      = (r_count == FULL) && !i_start_new;
    assign entry_idx = i_start_new ? '0 : r_count;

    always_comb begin
        if (i_start_new) begin
            n_count = CNT_W'(1);
        end else if (full) begin
            n_count = r_count;
        end else begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (en && i_valid) begin
            r_count <= n_count;
        end
    end

    assign c_ctl[0]   = '{valid: i_valid, start_new: i_start_new, too_many: full};
    assign c_value[0] = i_value;
    assign c_idx[0]   = entry_idx;
    assign c_cnt[0]   = '0;

    for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
        icu_cell #(
            .CNT_W    (CNT_W),
            .CELL_IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (c_ctl[k]),
            .i_value (c_value[k]),
            .i_idx   (c_idx[k]),
            .i_cnt   (c_cnt[k]),
            .o_ctl   (c_ctl[k+1]),
            .o_value (c_value[k+1]),
            .o_idx   (c_idx[k+1]),
            .o_cnt   (c_cnt[k+1])
        );
    end

    icu_total #(
        .CNT_W (CNT_W)
    ) u_total (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_ctl            (c_ctl[MAX_ITEMS]),
        .i_cnt            (c_cnt[MAX_ITEMS]),
        .o_valid          (o_valid),
        .o_greater_before (o_greater_before),
        .o_inversions     (o_inversions),
        .o_too_many       (o_too_many)
    );

    logic unused_tail;
    assign unused_tail = ^{c_value[MAX_ITEMS], c_idx[MAX_ITEMS]};

endmodule
